// ===== design/tsbe_pkg.sv =====
// Shared types, constants and address helper for the text screen buffer engine.
// Used by text_screen_buffer_engine; depends on nothing else.
`default_nettype none

package tsbe_pkg;

  // Screen geometry and field widths.
  localparam int MAX_COLS = 80;
  localparam int MAX_ROWS = 25;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int CHAR_W   = 8;
  localparam int CELL_W   = 16;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int PADDR_W  = 4;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

  // Configuration register indexes (paddr[3:2]).
  localparam logic [1:0] REG_COLS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_ATTR = 2'd2;

  typedef enum logic [3:0] {
    CMD_SETCOL      = 4'd0,
    CMD_SETROW      = 4'd1,
    CMD_INCCOL      = 4'd2,
    CMD_DECCOL      = 4'd3,
    CMD_INCROW      = 4'd4,
    CMD_DECROW      = 4'd5,
    CMD_TAB         = 4'd6,
    CMD_PUT         = 4'd7,
    CMD_DELETE      = 4'd8,
    CMD_INSERT      = 4'd9,
    CMD_ERASELINE   = 4'd10,
    CMD_ERASESCREEN = 4'd11,
    CMD_READ        = 4'd12
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_COPY_RD,
    S_COPY_WR,
    S_READ,
    S_RESP
  } state_t;

  // Linear memory address of a cell.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

// ===== design/tsbe_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the cell memory of the screen buffer engine.
`default_nettype none

module tsbe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/text_screen_buffer_engine.sv =====
// Top level of the text screen buffer engine: command sequencer, cursor,
// configuration registers and the cell memory (tsbe_ram). Uses tsbe_pkg.
//
// Usage: a command transfer is accepted at a rising edge with start high and
// busy low. Each command produces exactly one result, shown for one cycle with
// done high: the cursor after the command and the cell at (read_row, read_col).
// The receiver cannot stall; results must be taken when done is high.
// Cell memory is one 2000 x 16 RAM with one write and one registered read port;
// its port sets all timing below.
// Cursor moves, put and read pass through execute and respond, and the
// next command may be accepted in the respond cycle.
// Tab and erase line: execute, a fill walk over the cells written, read and
// respond. Erase screen carries the walk on through every later active row.
// Delete and insert: execute, a read and a write per moved cell, read, respond.
// Reset: a clearing pass writes zero to all 2000 cells, one per cycle, with
// busy high; configuration writes are taken during it. Registers reset to
// 80 columns, 25 rows and attribute 0; the cursor resets to the origin.
// Configuration is an APB-style port, registers at byte addresses 0, 4, 8.
`default_nettype none

module text_screen_buffer_engine (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Command channel
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [3:0]                     command,
  input  wire logic signed [7:0]              position_value,
  input  wire logic                           clamp_enable,
  input  wire logic                           advance_enable,
  input  wire logic [tsbe_pkg::CHAR_W-1:0]    char_code,
  input  wire logic [tsbe_pkg::ROW_W-1:0]     read_row,
  input  wire logic [tsbe_pkg::COL_W-1:0]     read_col,
  // Result channel
  output logic                                done,
  output logic      [tsbe_pkg::COL_W-1:0]     cursor_col,
  output logic      [tsbe_pkg::ROW_W-1:0]     cursor_row,
  output logic      [tsbe_pkg::CHAR_W-1:0]    cell_char,
  output logic      [tsbe_pkg::CHAR_W-1:0]    cell_attr,
  // Configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tsbe_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);

  import tsbe_pkg::*;

  localparam logic [COL_W-1:0] MAX_COLS_C = COL_W'(MAX_COLS);
  localparam logic [ROW_W-1:0] MAX_ROWS_C = ROW_W'(MAX_ROWS);

  state_t state, state_next;

  // Configuration registers.
  logic [COL_W-1:0]  cols_in_use;
  logic [ROW_W-1:0]  rows_in_use;
  logic [CHAR_W-1:0] current_attribute;

  // Captured command.
  cmd_t              cmd_q;
  logic signed [7:0] pos_q;
  logic              clamp_q;
  logic              adv_q;
  logic [CHAR_W-1:0] char_q;
  logic [ROW_W-1:0]  rrow_q;
  logic [COL_W-1:0]  rcol_q;

  // Cursor and walk state.
  logic [COL_W-1:0]  cursor_column;
  logic [ROW_W-1:0]  cursor_line;
  logic [COL_W-1:0]  walk_col;
  logic [ROW_W-1:0]  walk_row;
  logic [COL_W-1:0]  fill_end;
  logic [CELL_W-1:0] fill_data;
  logic              fill_screen;
  logic [ADDR_W-1:0] clr_addr;

  // Memory ports and read bypass.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;
  logic              fwd_hit;
  logic [CELL_W-1:0] fwd_data;
  logic              rd_ok;

  // Derived values.
  logic [COL_W-1:0]  w;
  logic [COL_W-1:0]  w_m1;
  logic [ROW_W-1:0]  h;
  logic              cur_in;
  logic [COL_W-1:0]  tab_target;
  logic              read_in;
  logic              copy_last;
  logic [COL_W-1:0]  copy_src;
  logic [CELL_W-1:0] cell_out;
  logic              cfg_write;

  // Cursor move with clamping or rejection at the edges.
  function automatic logic [COL_W-1:0] move_to(input logic signed [8:0] target,
                                               input logic [COL_W-1:0] current,
                                               input logic [COL_W-1:0] limit,
                                               input logic clamp);
    logic signed [8:0] lim_s;
    lim_s = $signed({2'b00, limit});
    if (target < 0) begin
      move_to = clamp ? '0 : current;
    end else if (target >= lim_s) begin
      move_to = clamp ? limit - 1'b1 : current;
    end else begin
      move_to = target[COL_W-1:0];
    end
  endfunction

  // Active area, clamped to the grid.
  always_comb begin
    if (cols_in_use == '0) begin
      w = COL_W'(1);
    end else if (cols_in_use > MAX_COLS_C) begin
      w = MAX_COLS_C;
    end else begin
      w = cols_in_use;
    end
    if (rows_in_use == '0) begin
      h = ROW_W'(1);
    end else if (rows_in_use > MAX_ROWS_C) begin
      h = MAX_ROWS_C;
    end else begin
      h = rows_in_use;
    end
  end

  assign w_m1    = w - 1'b1;
  assign cur_in  = (cursor_column < w);
  assign read_in = (rrow_q < h) && (rcol_q < w);

  // Tab target: negative acts as zero, beyond the last column acts as the last.
  always_comb begin
    if (pos_q < 0) begin
      tab_target = '0;
    end else if ($unsigned(pos_q) > {1'b0, w_m1}) begin
      tab_target = w_m1;
    end else begin
      tab_target = pos_q[COL_W-1:0];
    end
  end

  // Delete walks left to right, insert right to left; the last step blanks.
  always_comb begin
    if (cmd_q == CMD_DELETE) begin
      copy_last = (walk_col == w_m1);
      copy_src  = copy_last ? walk_col : walk_col + 1'b1;
    end else begin
      copy_last = (walk_col == cursor_column);
      copy_src  = copy_last ? walk_col : walk_col - 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE, S_RESP: begin
        if (start) begin
          state_next = S_EXEC;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EXEC: begin
        case (cmd_q)
          CMD_TAB, CMD_ERASELINE, CMD_ERASESCREEN: state_next = S_FILL;
          CMD_DELETE, CMD_INSERT: state_next = cur_in ? S_COPY_RD : S_RESP;
          default: state_next = S_RESP;
        endcase
      end
      S_FILL: begin
        if (walk_col >= fill_end &&
            !(fill_screen && ({1'b0, walk_row} + 1'b1 < {1'b0, h}))) begin
          state_next = S_READ;
        end
      end
      S_COPY_RD: state_next = S_COPY_WR;
      S_COPY_WR: state_next = copy_last ? S_READ : S_COPY_RD;
      S_READ:    state_next = S_RESP;
      default:   state_next = S_IDLE;
    endcase
  end

  // Outputs and memory control.
  always_comb begin
    busy      = 1'b1;
    done      = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cell_addr(cursor_line, cursor_column);
    ram_wdata = {current_attribute, char_q};
    ram_raddr = read_in ? cell_addr(rrow_q, rcol_q) : '0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_IDLE: begin
        busy = 1'b0;
      end
      S_RESP: begin
        busy = 1'b0;
        done = 1'b1;
      end
      S_EXEC: begin
        if (cmd_q == CMD_PUT && cur_in) begin
          ram_we = 1'b1;
        end
      end
      S_FILL: begin
        ram_waddr = cell_addr(walk_row, walk_col);
        ram_wdata = fill_data;
        ram_we    = (walk_col < fill_end);
      end
      S_COPY_RD: begin
        ram_raddr = cell_addr(cursor_line, copy_src);
      end
      S_COPY_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(cursor_line, walk_col);
        ram_wdata = copy_last ? {ram_rdata[CELL_W-1:CHAR_W], BLANK_CHAR} : ram_rdata;
      end
      default: begin
      end
    endcase
  end

  // Sequencer state and clearing pass counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Command capture (payload only).
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q   <= cmd_t'(command);
      pos_q   <= position_value;
      clamp_q <= clamp_enable;
      adv_q   <= advance_enable;
      char_q  <= char_code;
      rrow_q  <= read_row;
      rcol_q  <= read_col;
    end
  end

  // Cursor updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_line   <= '0;
    end else if (state == S_EXEC) begin
      case (cmd_q)
        CMD_SETCOL: cursor_column <= move_to({pos_q[7], pos_q}, cursor_column, w, clamp_q);
        CMD_SETROW: cursor_line <= ROW_W'(move_to({pos_q[7], pos_q}, COL_W'(cursor_line),
                                                  COL_W'(h), clamp_q));
        CMD_INCCOL: cursor_column <= move_to($signed({2'b00, cursor_column}) + 9'sd1,
                                             cursor_column, w, clamp_q);
        CMD_DECCOL: cursor_column <= move_to($signed({2'b00, cursor_column}) - 9'sd1,
                                             cursor_column, w, clamp_q);
        CMD_INCROW: cursor_line <= ROW_W'(move_to($signed({4'b0000, cursor_line}) + 9'sd1,
                                                  COL_W'(cursor_line), COL_W'(h), clamp_q));
        CMD_DECROW: cursor_line <= ROW_W'(move_to($signed({4'b0000, cursor_line}) - 9'sd1,
                                                  COL_W'(cursor_line), COL_W'(h), clamp_q));
        CMD_TAB: cursor_column <= tab_target;
        CMD_PUT: begin
          if (cur_in && adv_q && cursor_column < w_m1) begin
            cursor_column <= cursor_column + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Walk registers for fills and row shifts.
  always_ff @(posedge clk) begin
    case (state)
      S_EXEC: begin
        walk_row    <= cursor_line;
        fill_screen <= (cmd_q == CMD_ERASESCREEN);
        if (cmd_q == CMD_TAB) begin
          walk_col  <= cursor_column;
          fill_end  <= tab_target;
          fill_data <= {current_attribute, BLANK_CHAR};
        end else if (cmd_q == CMD_INSERT) begin
          walk_col  <= w_m1;
          fill_end  <= w;
          fill_data <= {current_attribute, {CHAR_W{1'b0}}};
        end else begin
          walk_col  <= cursor_column;
          fill_end  <= w;
          fill_data <= {current_attribute, {CHAR_W{1'b0}}};
        end
      end
      S_FILL: begin
        if (walk_col < fill_end) begin
          walk_col <= walk_col + 1'b1;
        end else begin
          walk_row <= walk_row + 1'b1;
          walk_col <= '0;
        end
      end
      S_COPY_WR: begin
        if (cmd_q == CMD_DELETE) begin
          walk_col <= walk_col + 1'b1;
        end else begin
          walk_col <= walk_col - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Read bypass for a write to the cell being read in the same cycle.
  always_ff @(posedge clk) begin
    fwd_hit  <= ram_we && (ram_waddr == ram_raddr);
    fwd_data <= ram_wdata;
    rd_ok    <= read_in;
  end

  tsbe_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result fields.
  assign cell_out   = !rd_ok ? '0 : (fwd_hit ? fwd_data : ram_rdata);
  assign cell_char  = cell_out[CHAR_W-1:0];
  assign cell_attr  = cell_out[CELL_W-1:CHAR_W];
  assign cursor_col = cursor_column;
  assign cursor_row = cursor_line;

  // Configuration port: a write transfer completes in the access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use       <= MAX_COLS_C;
      rows_in_use       <= MAX_ROWS_C;
      current_attribute <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_COLS: cols_in_use       <= pwdata[COL_W-1:0];
        REG_ROWS: rows_in_use       <= pwdata[ROW_W-1:0];
        REG_ATTR: current_attribute <= pwdata[CHAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COLS: prdata = {{(32 - COL_W){1'b0}}, cols_in_use};
      REG_ROWS: prdata = {{(32 - ROW_W){1'b0}}, rows_in_use};
      REG_ATTR: prdata = {{(32 - CHAR_W){1'b0}}, current_attribute};
      default:  prdata = '0;
    endcase
  end

  // A result is never shown in back-to-back cycles.
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // An accepted command always makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

  // Memory writes stay inside the grid.
  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (ram_waddr < ADDR_W'(DEPTH)))
    else $error("cell write outside the grid");

  // The cursor does not move while no command is in flight.
  a_cursor_idle: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> ($stable(cursor_column) && $stable(cursor_line)))
    else $error("cursor changed while idle");

endmodule

`default_nettype wire

// ===== bench/text_screen_buffer_engine_tb.sv =====
// Self-checking testbench for text_screen_buffer_engine: command results are
// checked against a behavioral model of the screen and its APB registers.
// Depends on tsbe_pkg and the design sources; reads no files.

module text_screen_buffer_engine_tb;
  import tsbe_pkg::*;

  // A full erase-screen walk plus the reset clearing pass stay well inside this.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 50;
  localparam int MAX_REPORTS    = 10;

  // Command codes that the block treats as no operation.
  localparam logic [3:0] CMD_SPARE_LO = 4'd13;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;

  // One command transfer as driven on the input ports.
  typedef struct {
    logic [3:0]        cmd;
    logic signed [7:0] pos;
    logic              clamp;
    logic              adv;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  rrow;
    logic [COL_W-1:0]  rcol;
  } screen_cmd_t;

  // Cursor and read-back cell as returned by the block.
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] attr;
  } screen_view_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [3:0]               command;
  logic signed [7:0]        position_value;
  logic                     clamp_enable;
  logic                     advance_enable;
  logic [CHAR_W-1:0]        char_code;
  logic [ROW_W-1:0]         read_row;
  logic [COL_W-1:0]         read_col;
  logic                     done;
  logic [COL_W-1:0]         cursor_col;
  logic [ROW_W-1:0]         cursor_row;
  logic [CHAR_W-1:0]        cell_char;
  logic [CHAR_W-1:0]        cell_attr;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [PADDR_W-1:0]       paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  // Screen model: cells, cursor and the three registers as last written.
  logic [CELL_W-1:0]        model_cells [DEPTH];
  int                       model_col;
  int                       model_row;
  int                       reg_cols;
  int                       reg_rows;
  logic [7:0]               reg_attr;

  screen_view_t             expected_views [$];
  int                       mismatches;
  int                       idle_pct;

  text_screen_buffer_engine DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .position_value (position_value),
    .clamp_enable   (clamp_enable),
    .advance_enable (advance_enable),
    .char_code      (char_code),
    .read_row       (read_row),
    .read_col       (read_col),
    .done           (done),
    .cursor_col     (cursor_col),
    .cursor_row     (cursor_row),
    .cell_char      (cell_char),
    .cell_attr      (cell_attr),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Effective width and height after saturating the register values.
  function automatic int active_width();
    if (reg_cols < 1) return 1;
    if (reg_cols > MAX_COLS) return MAX_COLS;
    return reg_cols;
  endfunction

  function automatic int active_height();
    if (reg_rows < 1) return 1;
    if (reg_rows > MAX_ROWS) return MAX_ROWS;
    return reg_rows;
  endfunction

  // Out-of-range targets either clamp to the edge or leave the cursor alone.
  function automatic int move_target(int target, int current, int limit, bit clamp);
    if (target < 0) return clamp ? 0 : current;
    if (target >= limit) return clamp ? limit - 1 : current;
    return target;
  endfunction

  function automatic void fill_cells(int row, int from, int to, logic [CELL_W-1:0] value);
    for (int x = from; x < to; x++) model_cells[row * MAX_COLS + x] = value;
  endfunction

  // Applies one command to the screen model and returns the expected result.
  function automatic screen_view_t predict_command(screen_cmd_t c);
    screen_view_t      v;
    int                w;
    int                h;
    int                pos;
    int                t;
    int                base;
    logic [CELL_W-1:0] cell_word;
    w    = active_width();
    h    = active_height();
    pos  = c.pos;
    base = model_row * MAX_COLS;
    case (c.cmd)
      CMD_SETCOL: model_col = move_target(pos, model_col, w, c.clamp);
      CMD_SETROW: model_row = move_target(pos, model_row, h, c.clamp);
      CMD_INCCOL: model_col = move_target(model_col + 1, model_col, w, c.clamp);
      CMD_DECCOL: model_col = move_target(model_col - 1, model_col, w, c.clamp);
      CMD_INCROW: model_row = move_target(model_row + 1, model_row, h, c.clamp);
      CMD_DECROW: model_row = move_target(model_row - 1, model_row, h, c.clamp);
      CMD_TAB: begin
        t = (pos < 0) ? 0 : pos;
        if (t > w - 1) t = w - 1;
        fill_cells(model_row, model_col, t, {reg_attr, BLANK_CHAR});
        model_col = t;
      end
      CMD_PUT: begin
        if (model_col < w) begin
          model_cells[base + model_col] = {reg_attr, c.ch};
          if (c.adv && model_col < w - 1) model_col++;
        end
      end
      CMD_DELETE: begin
        if (model_col < w) begin
          for (int x = model_col; x + 1 < w; x++)
            model_cells[base + x] = model_cells[base + x + 1];
          model_cells[base + w - 1] = {model_cells[base + w - 1][15:8], BLANK_CHAR};
        end
      end
      CMD_INSERT: begin
        if (model_col < w) begin
          for (int x = w - 1; x > model_col; x--)
            model_cells[base + x] = model_cells[base + x - 1];
          model_cells[base + model_col] = {model_cells[base + model_col][15:8], BLANK_CHAR};
        end
      end
      CMD_ERASELINE: fill_cells(model_row, model_col, w, {reg_attr, 8'h00});
      CMD_ERASESCREEN: begin
        fill_cells(model_row, model_col, w, {reg_attr, 8'h00});
        for (int r = model_row + 1; r < h; r++) fill_cells(r, 0, w, {reg_attr, 8'h00});
      end
      default: ;
    endcase
    cell_word = '0;
    if (c.rrow < h && c.rcol < w) cell_word = model_cells[c.rrow * MAX_COLS + c.rcol];
    v.col  = COL_W'(model_col);
    v.row  = ROW_W'(model_row);
    v.ch   = cell_word[7:0];
    v.attr = cell_word[15:8];
    return v;
  endfunction

  // Register setting for width or height: mostly in range, with both extremes
  // and out-of-range values that saturate. Upper bus bits carry noise.
  function automatic logic [31:0] pick_extent(int limit, int field_bits);
    int pick;
    int value;
    pick = $urandom_range(99);
    if (pick < 8) value = 0;
    else if (pick < 16) value = 1;
    else if (pick < 30) value = limit;
    else if (pick < 40) value = $urandom_range((1 << field_bits) - 1, limit + 1);
    else value = $urandom_range(limit - 1, 2);
    return ($urandom() << field_bits) | value;
  endfunction

  // Random command: mostly text entry and cursor motion near the active area,
  // with some full-range field values, shifts, erases and spare codes.
  function automatic screen_cmd_t random_command();
    screen_cmd_t c;
    int          pick;
    int          w;
    int          h;
    w       = active_width();
    h       = active_height();
    pick    = $urandom_range(99);
    c.clamp = $urandom_range(1);
    c.adv   = ($urandom_range(3) != 0);
    c.ch    = CHAR_W'($urandom_range(255));
    if (pick < 36) c.cmd = CMD_PUT;
    else if (pick < 44) c.cmd = CMD_SETCOL;
    else if (pick < 50) c.cmd = CMD_SETROW;
    else if (pick < 56) c.cmd = CMD_INCCOL;
    else if (pick < 61) c.cmd = CMD_DECCOL;
    else if (pick < 65) c.cmd = CMD_INCROW;
    else if (pick < 69) c.cmd = CMD_DECROW;
    else if (pick < 75) c.cmd = CMD_TAB;
    else if (pick < 81) c.cmd = CMD_DELETE;
    else if (pick < 87) c.cmd = CMD_INSERT;
    else if (pick < 91) c.cmd = CMD_ERASELINE;
    else if (pick < 93) c.cmd = CMD_ERASESCREEN;
    else if (pick < 98) c.cmd = CMD_READ;
    else c.cmd = 4'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
    if ($urandom_range(3) == 0) c.pos = 8'($urandom_range(255));
    else c.pos = 8'($urandom_range(((c.cmd == CMD_SETROW) ? h : w) + 1));
    if ($urandom_range(3) == 0) begin
      c.rrow = ROW_W'($urandom_range(31));
      c.rcol = COL_W'($urandom_range(127));
    end else begin
      c.rrow = ROW_W'(model_row);
      c.rcol = COL_W'($urandom_range(1) ? model_col : $urandom_range(w - 1));
    end
    return c;
  endfunction

  // Drives one command transfer after a random gap and records its expected result.
  // Entered and left at a falling edge; start stays high on return.
  task automatic send_command(screen_cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    command        = c.cmd;
    position_value = c.pos;
    clamp_enable   = c.clamp;
    advance_enable = c.adv;
    char_code      = c.ch;
    read_row       = c.rrow;
    read_col       = c.rcol;
    start          = 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    expected_views = {expected_views, predict_command(c)};
    @(negedge clk);
  endtask

  task automatic send_fields(logic [3:0] cmd, int pos, bit clamp, bit adv,
                             logic [CHAR_W-1:0] ch, int rrow, int rcol);
    screen_cmd_t c;
    c.cmd   = cmd;
    c.pos   = 8'(pos);
    c.clamp = clamp;
    c.adv   = adv;
    c.ch    = ch;
    c.rrow  = ROW_W'(rrow);
    c.rcol  = COL_W'(rcol);
    send_command(c);
  endtask

  // Holds off new commands until every outstanding result has been seen.
  task automatic wait_results_drained();
    start = 1'b0;
    while (expected_views.size() != 0) @(negedge clk);
  endtask

  // Writes all three registers back to back over APB; no command is started meanwhile.
  task automatic configure_screen(logic [31:0] cols, logic [31:0] rows, logic [31:0] attr);
    logic [31:0] values [3];
    logic [1:0]  regs [3];
    values = '{cols, rows, attr};
    regs   = '{REG_COLS, REG_ROWS, REG_ATTR};
    start  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {regs[i], 2'b00};
      pwdata  = values[i];
      @(negedge clk);
      penable = 1'b1;
      @(posedge clk);
      while (pready !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    reg_cols = cols[6:0];
    reg_rows = rows[4:0];
    reg_attr = attr[7:0];
  endtask

  // Cursor motion at both edges, with and without clamping.
  task automatic test_cursor_moves();
    configure_screen(MAX_COLS, MAX_ROWS, 32'h0000_00A5);
    send_fields(CMD_SETCOL, -128, 0, 0, 8'h00, 0, 0);
    send_fields(CMD_SETCOL, 127, 0, 0, 8'h00, 0, 0);
    send_fields(CMD_SETCOL, 127, 1, 0, 8'h00, 0, 0);
    send_fields(CMD_INCCOL, 0, 0, 0, 8'h00, 0, 0);
    send_fields(CMD_INCCOL, 0, 1, 0, 8'h00, 0, 0);
    send_fields(CMD_SETCOL, -128, 1, 0, 8'h00, 0, 0);
    send_fields(CMD_DECCOL, 0, 0, 0, 8'h00, 0, 0);
    send_fields(CMD_DECCOL, 0, 1, 0, 8'h00, 0, 0);
    send_fields(CMD_SETROW, 127, 1, 0, 8'h00, 0, 0);
    send_fields(CMD_INCROW, 0, 1, 0, 8'h00, 0, 0);
    send_fields(CMD_SETROW, -128, 1, 0, 8'h00, 0, 0);
    send_fields(CMD_DECROW, 0, 0, 0, 8'h00, 0, 0);
  endtask

  // Put at the right edge, tab, shifts, erases and reads outside the screen.
  task automatic test_cell_edits();
    send_fields(CMD_SETCOL, 78, 1, 0, 8'h00, 0, 0);
    send_fields(CMD_PUT, 0, 0, 1, 8'hFF, 0, 78);
    send_fields(CMD_PUT, 0, 0, 1, 8'h00, 0, 79);
    send_fields(CMD_SETCOL, 2, 1, 0, 8'h00, 0, 0);
    send_fields(CMD_TAB, 12, 0, 0, 8'h00, 0, 5);
    send_fields(CMD_INSERT, 0, 0, 0, 8'h00, 0, 79);
    send_fields(CMD_DELETE, 0, 0, 0, 8'h00, 0, 79);
    send_fields(CMD_ERASELINE, 0, 0, 0, 8'h00, 0, 11);
    send_fields(CMD_TAB, -128, 0, 0, 8'h00, 0, 0);
    send_fields(CMD_SETROW, 23, 1, 0, 8'h00, 23, 0);
    send_fields(CMD_ERASESCREEN, 0, 0, 0, 8'h00, 24, 79);
    send_fields(CMD_READ, 0, 0, 0, 8'h00, 31, 127);
    send_fields(CMD_SPARE_HI, 127, 1, 1, 8'hFF, 23, 0);
  endtask

  // Smallest screen with the cursor left outside it, then saturated sizes.
  task automatic test_narrow_screen();
    send_fields(CMD_SETCOL, 79, 1, 0, 8'h00, 0, 0);
    wait_results_drained();
    configure_screen(32'd0, 32'd0, 32'h0000_00FF);
    send_fields(CMD_PUT, 0, 0, 1, 8'h41, 0, 0);
    send_fields(CMD_DELETE, 0, 0, 0, 8'h00, 0, 0);
    send_fields(CMD_ERASESCREEN, 0, 0, 0, 8'h00, 0, 0);
    send_fields(CMD_TAB, 5, 0, 0, 8'h00, 0, 0);
    send_fields(CMD_PUT, 0, 0, 1, 8'h58, 23, 0);
    send_fields(CMD_READ, 0, 0, 0, 8'h00, 0, 0);
    wait_results_drained();
    configure_screen(32'd127, 32'd31, 32'd0);
  endtask

  // Random traffic in three idling phases, reconfigured between segments
  // after every outstanding result has arrived.
  task automatic test_random_text();
    int pct [3];
    pct = '{37, 45, 0};
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = pct[phase];
      for (int seg = 0; seg < 4; seg++) begin
        wait_results_drained();
        configure_screen(pick_extent(MAX_COLS, COL_W), pick_extent(MAX_ROWS, ROW_W),
                         $urandom());
        repeat (58) send_command(random_command());
      end
    end
  endtask

  // Each result transfer is checked against the oldest expectation.
  always @(posedge clk) begin : check_results
    screen_view_t want;
    if (!rst && done === 1'b1) begin
      if (expected_views.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: col %0d row %0d char %h attr %h",
                   cursor_col, cursor_row, cell_char, cell_attr);
        mismatches++;
      end else begin
        want = expected_views.pop_front();
        if (cursor_col !== want.col || cursor_row !== want.row ||
            cell_char !== want.ch || cell_attr !== want.attr) begin
          if (mismatches < MAX_REPORTS)
            $display("mismatch: exp col/row %0d/%0d char/attr %h/%h, got %0d/%0d %h/%h",
                     want.col, want.row, want.ch, want.attr,
                     cursor_col, cursor_row, cell_char, cell_attr);
          mismatches++;
        end
      end
    end
  end

  // Ends the run when no transfer of any kind happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done === 1'b1 || (psel && penable)) quiet = 0;
      else quiet++;
    end
    $display("text_screen_buffer_engine verification failed");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    command        = CMD_READ;
    position_value = '0;
    clamp_enable   = 1'b0;
    advance_enable = 1'b0;
    char_code      = '0;
    read_row       = '0;
    read_col       = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mismatches     = 0;
    idle_pct       = 37;
    model_col      = 0;
    model_row      = 0;
    reg_cols       = MAX_COLS;
    reg_rows       = MAX_ROWS;
    reg_attr       = '0;
    foreach (model_cells[i]) model_cells[i] = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_cursor_moves();
    test_cell_edits();
    test_narrow_screen();
    test_random_text();

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_views.size() == 0) begin
      $display("text_screen_buffer_engine verification clean");
    end else begin
      $display("text_screen_buffer_engine verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tsbe_pkg.sv
design/tsbe_ram.sv
design/text_screen_buffer_engine.sv
bench/text_screen_buffer_engine_tb.sv
